// ===== design/rtps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_pkg
// Types and constants shared by the RTP receive statistics block.
// ----------------------------------------------------------------------------
package rtps_pkg;

  localparam logic [1:0]  VERSION_ACCEPTED = 2'd2;
  localparam logic [31:0] WINDOW_RESET_MS  = 32'd10000;
  localparam logic [31:0] CNT_MAX          = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  hdr_version;
    logic [15:0] seq_number;
    logic [31:0] rtp_timestamp;
    logic [31:0] source_id;
    logic [63:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] expected_count;
    logic [31:0] received_count;
    logic [31:0] wrap_count;
    logic [31:0] latched_source;
    logic [15:0] last_seq;
    logic [31:0] last_timestamp;
  } out_beat_t;

  typedef logic [31:0] cfg_word_t;

  // saturating 32-bit add
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? CNT_MAX : s[31:0];
  endfunction

endpackage

// ===== design/rtps_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface rtps_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/rtps_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_in_stage
// Input register: captures one header beat and holds it until consumed.
// ----------------------------------------------------------------------------
module rtps_in_stage
  import rtps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rtps_chan_if.sink in_ch,
  input  logic      take,
  output logic      stage_valid,
  output in_beat_t  stage_data
);

  logic     valid_r;
  logic     valid_nxt;
  in_beat_t data_r;
  logic     load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_ch.payload;
    end
  end

  assign stage_valid = valid_r;
  assign stage_data  = data_r;

endmodule

// ===== design/rtps_stats_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_stats_core
// Window, sequence and source statistics with the result register.
// ----------------------------------------------------------------------------
module rtps_stats_core
  import rtps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        stage_valid,
  input  in_beat_t    stage_data,
  output logic        take,
  rtps_chan_if.sink   cfg_ch,
  rtps_chan_if.source out_ch
);

  logic [31:0] window_ms_r;
  logic [63:0] window_start_r, window_start_nxt;
  logic [31:0] expected_r, expected_nxt;
  logic [31:0] received_r, received_nxt;
  logic [31:0] wraps_r, wraps_nxt;
  logic [31:0] source_r, source_nxt;
  logic [15:0] prev_seq_r, prev_seq_nxt;
  logic [31:0] prev_ts_r, prev_ts_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_data_r, out_data_nxt;

  logic        ok;
  logic        restart;
  logic [63:0] elapsed;
  logic [31:0] exp_base, rcv_base;
  logic [15:0] gap;

  assign cfg_ch.ready = 1'b1;
  assign take = stage_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    ok      = (stage_data.hdr_version == VERSION_ACCEPTED);
    elapsed = stage_data.now_ms - window_start_r;
    restart = (window_start_r == 64'd0) || (elapsed >= {32'd0, window_ms_r});
    exp_base = restart ? 32'd0 : expected_r;
    rcv_base = restart ? 32'd0 : received_r;
    gap      = stage_data.seq_number - prev_seq_r;

    window_start_nxt = window_start_r;
    expected_nxt     = expected_r;
    received_nxt     = received_r;
    wraps_nxt        = wraps_r;
    source_nxt       = source_r;
    prev_seq_nxt     = prev_seq_r;
    prev_ts_nxt      = prev_ts_r;

    if (ok) begin
      if (restart) begin
        window_start_nxt = stage_data.now_ms;
      end
      if (source_r == 32'd0) begin
        source_nxt = stage_data.source_id;
      end
      if (stage_data.seq_number < prev_seq_r) begin
        wraps_nxt = sat_add(wraps_r, 32'd1);
      end
      if (prev_seq_r == 16'd0 && rcv_base == 32'd0) begin
        expected_nxt = 32'd1;
      end else begin
        expected_nxt = sat_add(exp_base, {16'd0, gap});
      end
      received_nxt = sat_add(rcv_base, 32'd1);
      prev_seq_nxt = stage_data.seq_number;
      prev_ts_nxt  = stage_data.rtp_timestamp;
    end

    out_data_nxt.accepted       = ok;
    out_data_nxt.expected_count = expected_nxt;
    out_data_nxt.received_count = received_nxt;
    out_data_nxt.wrap_count     = wraps_nxt;
    out_data_nxt.latched_source = source_nxt;
    out_data_nxt.last_seq       = prev_seq_nxt;
    out_data_nxt.last_timestamp = prev_ts_nxt;

    out_valid_nxt = take || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r    <= WINDOW_RESET_MS;
      window_start_r <= 64'd0;
      expected_r     <= 32'd0;
      received_r     <= 32'd0;
      wraps_r        <= 32'd0;
      source_r       <= 32'd0;
      prev_seq_r     <= 16'd0;
      prev_ts_r      <= 32'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        window_ms_r <= cfg_ch.payload;
      end
      if (take) begin
        window_start_r <= window_start_nxt;
        expected_r     <= expected_nxt;
        received_r     <= received_nxt;
        wraps_r        <= wraps_nxt;
        source_r       <= source_nxt;
        prev_seq_r     <= prev_seq_nxt;
        prev_ts_r      <= prev_ts_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

endmodule

// ===== design/rtp_receive_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_receive_statistics
// RTP receive statistics: windowed expected/received counts, sequence wraps,
// latched source identifier and last sequence/timestamp.
//
// in_ch  : one RTP header beat (version, sequence, timestamp, SSRC, now_ms).
// out_ch : one statistics beat per header beat, in order; accepted is 0 for
//          headers whose version is not 2, which leave the state untouched.
// cfg_ch : window_ms write beat, always ready; write only while idle.
// Path: a header is held in the input register, then its result in the result register.
// Throughput: one beat per cycle while out_ch.ready is high; the state update is
// a combinational compare (64-bit elapsed time) and saturating add between the
// input register and the result register.
// Reset: counts, source, sequence and timestamp clear, window_ms = 10000,
// both stages empty.
// Stall: a held result keeps its beat; one more header still enters the
// input register, then in_ch.ready drops until out_ch.ready returns.
// ----------------------------------------------------------------------------
module rtp_receive_statistics
  import rtps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rtps_chan_if.sink   in_ch,
  rtps_chan_if.sink   cfg_ch,
  rtps_chan_if.source out_ch
);

  logic     take;
  logic     stage_valid;
  in_beat_t stage_data;

  rtps_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .take        (take),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  rtps_stats_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .stage_data  (stage_data),
    .take        (take),
    .cfg_ch      (cfg_ch),
    .out_ch      (out_ch)
  );

endmodule
